// ===== src/sprd_pkg.sv =====
package sprd_pkg;

  // Fixed field widths of the byte stream and the pixel results
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned PIX_IDX_W   = 12;
  localparam int unsigned CONSUMED_W  = 18;
  localparam int unsigned GATHER_W    = 24;
  localparam int unsigned BIP_W       = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_SPRITES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE    = 1'd1;

  // Constants of the record format
  localparam int unsigned SMALL_SIDE     = 32;
  localparam int unsigned RUN_HDR_BYTES  = 4;
  localparam logic [BYTE_W-1:0]     OPAQUE_ALPHA = 8'hFF;
  localparam logic [CONSUMED_W-1:0] CONSUMED_MAX = 18'h3FFFF;

  // One decoded result
  typedef struct packed {
    logic                  pixel_valid;
    logic [PIX_IDX_W-1:0]  pixel_index;
    logic [BYTE_W-1:0]     red;
    logic [BYTE_W-1:0]     green;
    logic [BYTE_W-1:0]     blue;
    logic [BYTE_W-1:0]     alpha;
    logic                  record_done;
  } result_t;

endpackage

// ===== src/sprd_if.sv =====
// Byte stream into the decoder
interface sprd_in_if
  import sprd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              record_start;

  modport source (output valid, data_byte, record_start, input ready);
  modport sink   (input valid, data_byte, record_start, output ready);
endinterface

// Pixel results out of the decoder
interface sprd_out_if
  import sprd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 pixel_valid;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [BYTE_W-1:0]    red;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    blue;
  logic [BYTE_W-1:0]    alpha;
  logic                 record_done;

  modport source (output valid, pixel_valid, pixel_index, red, green, blue, alpha,
                  record_done, input ready);
  modport sink   (input valid, pixel_valid, pixel_index, red, green, blue, alpha,
                  record_done, output ready);
endinterface

// Configuration register writes
interface sprd_cfg_if
  import sprd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 value;

  modport source (output valid, index, value, input ready);
  modport sink   (input valid, index, value, output ready);
endinterface

// ===== src/sprd_core.sv =====
module sprd_core
  import sprd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              record_start,
  input  logic              large_sprites,
  input  logic              alpha_mode,
  output logic              has_result,
  output result_t           res
);

  localparam int unsigned TOTAL_LARGE = MAX_SIDE * MAX_SIDE;
  localparam int unsigned TOTAL_SMALL = SMALL_SIDE * SMALL_SIDE;
  localparam int unsigned POS_W       = $clog2(TOTAL_LARGE + 1);

  // Decoder phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_KEY0     = 4'd1;
  localparam logic [3:0] PH_KEY1     = 4'd2;
  localparam logic [3:0] PH_KEY2     = 4'd3;
  localparam logic [3:0] PH_SIZE_LO  = 4'd4;
  localparam logic [3:0] PH_SIZE_HI  = 4'd5;
  localparam logic [3:0] PH_TRANS_LO = 4'd6;
  localparam logic [3:0] PH_TRANS_HI = 4'd7;
  localparam logic [3:0] PH_COL_LO   = 4'd8;
  localparam logic [3:0] PH_COL_HI   = 4'd9;
  localparam logic [3:0] PH_COLOR    = 4'd10;
  localparam logic [3:0] PH_DONE     = 4'd11;

  logic [3:0]            phase, phase_next, phase_eff;
  logic [WORD_W-1:0]     payload_size, payload_size_next, payload_size_eff;
  logic [CONSUMED_W-1:0] consumed, consumed_next, consumed_eff;
  logic [POS_W-1:0]      pos, pos_next, pos_eff;
  logic [WORD_W-1:0]     run_count, run_count_next, run_count_eff;
  logic [BIP_W-1:0]      bip, bip_next, bip_eff;
  logic [GATHER_W-1:0]   gather, gather_next, gather_eff;
  logic [BYTE_W-1:0]     low_hold, low_hold_next, low_hold_eff;

  logic [POS_W-1:0]      total;
  logic [WORD_W-1:0]     word;
  logic [WORD_W:0]       trans_sum;
  logic [CONSUMED_W-1:0] run_bytes;
  logic [CONSUMED_W:0]   cons_sum;
  logic [CONSUMED_W-1:0] cons_sat;
  logic [POS_W-1:0]      pos_inc;
  logic [WORD_W-1:0]     run_dec;
  logic                  last_byte;
  logic                  done;

  assign total = large_sprites ? POS_W'(TOTAL_LARGE) : POS_W'(TOTAL_SMALL);
  assign word  = {data_byte, low_hold_eff};

  // A record start wipes the record state before this byte is decoded
  always_comb begin
    if (record_start) begin
      phase_eff        = large_sprites ? PH_SIZE_LO : PH_KEY0;
      payload_size_eff = '0;
      consumed_eff     = '0;
      pos_eff          = '0;
      run_count_eff    = '0;
      bip_eff          = '0;
      gather_eff       = '0;
      low_hold_eff     = '0;
    end else begin
      phase_eff        = phase;
      payload_size_eff = payload_size;
      consumed_eff     = consumed;
      pos_eff          = pos;
      run_count_eff    = run_count;
      bip_eff          = bip;
      gather_eff       = gather;
      low_hold_eff     = low_hold;
    end
  end

  // Run arithmetic: skip with saturation at image end, payload bytes with saturation
  assign trans_sum = (WORD_W+1)'(pos_eff) + (WORD_W+1)'(word);
  assign run_bytes = alpha_mode ? {word, 2'b00}
                                : ({1'b0, word, 1'b0} + {2'b00, word});
  assign cons_sum  = (CONSUMED_W+1)'(consumed_eff) + (CONSUMED_W+1)'(RUN_HDR_BYTES)
                   + (CONSUMED_W+1)'(run_bytes);
  assign cons_sat  = cons_sum[CONSUMED_W] ? CONSUMED_MAX : cons_sum[CONSUMED_W-1:0];
  assign pos_inc   = pos_eff + POS_W'(1);
  assign run_dec   = run_count_eff - WORD_W'(1);
  assign last_byte = alpha_mode ? (bip_eff == BIP_W'(3)) : (bip_eff == BIP_W'(2));
  assign done      = (pos_inc >= total)
                   || ((run_dec == '0) && (consumed_eff >= CONSUMED_W'(payload_size_eff)));

  // Byte decode
  always_comb begin
    phase_next        = phase_eff;
    payload_size_next = payload_size_eff;
    consumed_next     = consumed_eff;
    pos_next          = pos_eff;
    run_count_next    = run_count_eff;
    bip_next          = bip_eff;
    gather_next       = gather_eff;
    low_hold_next     = low_hold_eff;
    has_result        = 1'b0;
    res               = '0;
    unique case (phase_eff) inside
      PH_KEY0: phase_next = PH_KEY1;
      PH_KEY1: phase_next = PH_KEY2;
      PH_KEY2: phase_next = PH_SIZE_LO;
      PH_SIZE_LO, PH_TRANS_LO, PH_COL_LO: begin
        low_hold_next = data_byte;
        phase_next    = phase_eff + 4'd1;
      end
      PH_SIZE_HI: begin
        payload_size_next = word;
        if (word == '0) begin
          phase_next      = PH_DONE;
          has_result      = 1'b1;
          res.record_done = 1'b1;
        end else begin
          phase_next = PH_TRANS_LO;
        end
      end
      PH_TRANS_HI: begin
        pos_next   = (trans_sum > (WORD_W+1)'(total)) ? total : POS_W'(trans_sum);
        phase_next = PH_COL_LO;
      end
      PH_COL_HI: begin
        consumed_next = cons_sat;
        if (pos_eff >= total) begin
          phase_next      = PH_DONE;
          has_result      = 1'b1;
          res.record_done = 1'b1;
        end else if (word == '0) begin
          if (cons_sat >= CONSUMED_W'(payload_size_eff)) begin
            phase_next      = PH_DONE;
            has_result      = 1'b1;
            res.record_done = 1'b1;
          end else begin
            phase_next = PH_TRANS_LO;
          end
        end else begin
          run_count_next = word;
          bip_next       = '0;
          gather_next    = '0;
          phase_next     = PH_COLOR;
        end
      end
      PH_COLOR: begin
        if (!last_byte) begin
          case (bip_eff)
            2'd0:    gather_next[7:0]   = data_byte;
            2'd1:    gather_next[15:8]  = data_byte;
            2'd2:    gather_next[23:16] = data_byte;
            default: gather_next        = gather_eff;
          endcase
          bip_next = bip_eff + BIP_W'(1);
        end else begin
          has_result      = 1'b1;
          res.pixel_valid = 1'b1;
          res.pixel_index = PIX_IDX_W'(pos_eff);
          res.red         = gather_eff[7:0];
          res.green       = gather_eff[15:8];
          res.blue        = alpha_mode ? gather_eff[23:16] : data_byte;
          res.alpha       = alpha_mode ? data_byte : OPAQUE_ALPHA;
          res.record_done = done;
          pos_next        = pos_inc;
          run_count_next  = run_dec;
          bip_next        = '0;
          gather_next     = '0;
          if (done) begin
            phase_next = PH_DONE;
          end else if (run_dec == '0) begin
            phase_next = PH_TRANS_LO;
          end
        end
      end
      default: begin
        // idle or finished: bytes without a record start are dropped
        phase_next = phase_eff;
      end
    endcase
  end

  // Record state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      payload_size <= '0;
      consumed     <= '0;
      pos          <= '0;
      run_count    <= '0;
      bip          <= '0;
      gather       <= '0;
      low_hold     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      payload_size <= payload_size_next;
      consumed     <= consumed_next;
      pos          <= pos_next;
      run_count    <= run_count_next;
      bip          <= bip_next;
      gather       <= gather_next;
      low_hold     <= low_hold_next;
    end
  end

  // A done result always leaves the decoder finished
  assert property (@(posedge clk) disable iff (rst)
    (accept && has_result && res.record_done) |=> (phase == PH_DONE))
    else $error("record_done given but decoder not finished");

  // Position never passes the large-sprite image end
  assert property (@(posedge clk) disable iff (rst)
    (pos <= POS_W'(TOTAL_LARGE)))
    else $error("pixel position beyond image end");

endmodule

// ===== src/sprd_skid.sv =====
module sprd_skid
  import sprd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    sk_valid;
  result_t sk_data;
  logic    pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !sk_valid;

  // Output register backed by one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!out_valid || pop) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  // Payload moves
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (sk_valid) begin
        out_data <= sk_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      sk_data <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) sk_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  assert property (@(posedge clk) disable iff (rst) push |-> !sk_valid)
    else $error("push into full buffer");

  assert property (@(posedge clk) disable iff (rst)
    (pop && sk_valid) |=> (out_valid && (out_data == $past(sk_data))))
    else $error("skid entry not moved to output register");

endmodule

// ===== src/sprite_run_length_decoder.sv =====
// Sprite run-length decoder. Takes one sprite record a byte per transaction
// on data_in (record_start on the first byte) and gives colored-pixel writes
// on pixel_out; transparent runs give nothing, and the last result of a record
// has record_done set (a header-only end gives one result with pixel_valid 0).
// One byte is accepted every cycle while data_in.ready is high: each byte
// updates the counter set in the decoder and its result is registered,
// appearing on pixel_out the cycle after acceptance unless pixel_out is
// stalled. A two-entry output buffer (output register plus skid entry) holds
// results, and data_in.ready drops only while both are full.
// Write large_sprites and alpha_mode through cfg between records only.
module sprite_run_length_decoder
  import sprd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  sprd_in_if.sink     data_in,
  sprd_out_if.source  pixel_out,
  sprd_cfg_if.sink    cfg
);

  logic    large_sprites;
  logic    alpha_mode;
  logic    accept;
  logic    has_result;
  logic    push_ready;
  result_t res;
  result_t out_data;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      large_sprites <= 1'b0;
      alpha_mode    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LARGE_SPRITES: large_sprites <= cfg.value;
        REG_ALPHA_MODE:    alpha_mode    <= cfg.value;
        default:           large_sprites <= large_sprites;
      endcase
    end
  end

  assign data_in.ready = push_ready;
  assign accept        = data_in.valid && push_ready;

  sprd_core #(
    .MAX_SIDE(MAX_SIDE)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_in.data_byte),
    .record_start (data_in.record_start),
    .large_sprites(large_sprites),
    .alpha_mode   (alpha_mode),
    .has_result   (has_result),
    .res          (res)
  );

  sprd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && has_result),
    .push_data (res),
    .push_ready(push_ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .out_data  (out_data)
  );

  assign pixel_out.pixel_valid = out_data.pixel_valid;
  assign pixel_out.pixel_index = out_data.pixel_index;
  assign pixel_out.red         = out_data.red;
  assign pixel_out.green       = out_data.green;
  assign pixel_out.blue        = out_data.blue;
  assign pixel_out.alpha       = out_data.alpha;
  assign pixel_out.record_done = out_data.record_done;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import sprd_pkg::*;

  localparam int unsigned MAX_SIDE      = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_BYTES  = 650;
  localparam int unsigned PHASE_BYTES   = 110;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Decoder position within a record
  typedef enum logic [3:0] {
    DEC_IDLE, DEC_KEY0, DEC_KEY1, DEC_KEY2, DEC_SIZE_LO, DEC_SIZE_HI,
    DEC_TRANS_LO, DEC_TRANS_HI, DEC_COL_LO, DEC_COL_HI, DEC_COLOR, DEC_DONE
  } dec_phase_t;

  // One byte of the input stream
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] data;
  } rec_byte_t;

  // Tracks the decoder state and checks every pixel transaction in order
  class pixel_checker;
    bit                    large_mode;
    bit                    alpha_on;
    dec_phase_t            phase;
    logic [WORD_W-1:0]     size;
    logic [CONSUMED_W-1:0] consumed;
    logic [12:0]           position;
    logic [WORD_W-1:0]     run_left;
    logic [BIP_W-1:0]      byte_idx;
    logic [GATHER_W-1:0]   gather;
    logic [BYTE_W-1:0]     low_hold;
    result_t               expected_pixels[$];
    int unsigned           errors;

    function new();
      large_mode = 1'b0;
      alpha_on   = 1'b0;
      errors     = 0;
      clear_record(DEC_IDLE);
    endfunction

    function void clear_record(dec_phase_t first);
      phase    = first;
      size     = '0;
      consumed = '0;
      position = '0;
      run_left = '0;
      byte_idx = '0;
      gather   = '0;
      low_hold = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      if (idx == REG_LARGE_SPRITES) large_mode = val;
      else if (idx == REG_ALPHA_MODE) alpha_on = val;
    endfunction

    // Advance the decoder by one accepted byte, queue the pixel it yields
    function void note_byte(logic [BYTE_W-1:0] data, logic start);
      int unsigned total;
      int unsigned bpp;
      int unsigned word;
      int unsigned sum;
      result_t     res;
      bit          emit;
      bit          done;
      total = large_mode ? MAX_SIDE * MAX_SIDE : SMALL_SIDE * SMALL_SIDE;
      bpp   = alpha_on ? 4 : 3;
      res   = '0;
      emit  = 1'b0;
      if (start) clear_record(large_mode ? DEC_SIZE_LO : DEC_KEY0);
      case (phase)
        DEC_KEY0: phase = DEC_KEY1;
        DEC_KEY1: phase = DEC_KEY2;
        DEC_KEY2: phase = DEC_SIZE_LO;
        DEC_SIZE_LO: begin
          low_hold = data;
          phase    = DEC_SIZE_HI;
        end
        DEC_SIZE_HI: begin
          size = {data, low_hold};
          if (size == '0) begin
            emit            = 1'b1;
            res.record_done = 1'b1;
            phase           = DEC_DONE;
          end else begin
            phase = DEC_TRANS_LO;
          end
        end
        DEC_TRANS_LO: begin
          low_hold = data;
          phase    = DEC_TRANS_HI;
        end
        DEC_TRANS_HI: begin
          // transparent skip saturates at the image end
          sum      = position + {data, low_hold};
          position = (sum > total) ? 13'(total) : 13'(sum);
          phase    = DEC_COL_LO;
        end
        DEC_COL_LO: begin
          low_hold = data;
          phase    = DEC_COL_HI;
        end
        DEC_COL_HI: begin
          word     = {data, low_hold};
          sum      = consumed + RUN_HDR_BYTES + bpp * word;
          consumed = (sum > CONSUMED_MAX) ? CONSUMED_MAX : CONSUMED_W'(sum);
          // header-only end: image full, or an empty run closes the payload
          if (position >= total || (word == 0 && consumed >= size)) begin
            emit            = 1'b1;
            res.record_done = 1'b1;
            phase           = DEC_DONE;
          end else if (word == 0) begin
            phase = DEC_TRANS_LO;
          end else begin
            run_left = word;
            byte_idx = '0;
            gather   = '0;
            phase    = DEC_COLOR;
          end
        end
        DEC_COLOR: begin
          if (byte_idx + 1 < bpp) begin
            gather[8*byte_idx +: 8] = data;
            byte_idx = byte_idx + BIP_W'(1);
          end else begin
            emit            = 1'b1;
            res.pixel_valid = 1'b1;
            res.pixel_index = position[PIX_IDX_W-1:0];
            res.red         = gather[7:0];
            res.green       = gather[15:8];
            res.blue        = alpha_on ? gather[23:16] : data;
            res.alpha       = alpha_on ? data : OPAQUE_ALPHA;
            position        = position + 13'd1;
            run_left        = run_left - WORD_W'(1);
            byte_idx        = '0;
            gather          = '0;
            done = (position >= total) || (run_left == 0 && consumed >= size);
            res.record_done = done;
            if (done) phase = DEC_DONE;
            else if (run_left == 0) phase = DEC_TRANS_LO;
          end
        end
        default: ;
      endcase
      if (emit) expected_pixels.push_back(res);
    endfunction

    function string show(result_t r);
      return $sformatf("valid=%0b idx=%0d rgba=%02h_%02h_%02h_%02h done=%0b",
                       r.pixel_valid, r.pixel_index, r.red, r.green, r.blue,
                       r.alpha, r.record_done);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (expected_pixels.size() == 0) begin
        flag($sformatf("unexpected transaction %s", show(got)));
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want)
          flag($sformatf("expected %s, got %s", show(want), show(got)));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  bit          gap_free = 1'b0;
  int unsigned cycle_count = 0;
  result_t     seen_px;
  rec_byte_t   stim[$];
  pixel_checker chk;

  sprd_in_if  in_ch ();
  sprd_out_if px_ch ();
  sprd_cfg_if cfg_ch ();

  sprite_run_length_decoder #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .data_in   (in_ch),
    .pixel_out (px_ch),
    .cfg       (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixel side backpressure
  always @(negedge clk) begin
    px_ch.ready <= gap_free || ($urandom_range(99) >= 30);
  end

  // Output monitor and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && px_ch.valid && px_ch.ready) begin
      seen_px = {px_ch.pixel_valid, px_ch.pixel_index, px_ch.red, px_ch.green,
                 px_ch.blue, px_ch.alpha, px_ch.record_done};
      chk.check_pixel(seen_px);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sprite_run_length_decoder");
      $finish;
    end
  end

  task automatic send_byte(rec_byte_t b);
    @(negedge clk);
    while (!gap_free && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b.data;
    in_ch.record_start <= b.start;
    do @(posedge clk); while (!in_ch.ready);
    chk.note_byte(b.data, b.start);
  endtask

  task automatic send_stream();
    foreach (stim[i]) send_byte(stim[i]);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    stim.delete();
  endtask

  // Wait for all pixels, then let a header-only byte finish in the pipe
  task automatic settle_idle();
    while (chk.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    chk.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(bit large_sel, bit alpha_on);
    settle_idle();
    if ($urandom_range(1)) begin
      write_reg(REG_LARGE_SPRITES, large_sel);
      write_reg(REG_ALPHA_MODE, alpha_on);
    end else begin
      write_reg(REG_ALPHA_MODE, alpha_on);
      write_reg(REG_LARGE_SPRITES, large_sel);
    end
  endtask

  function automatic void push_word(ref rec_byte_t q[$], input int unsigned w);
    q.push_back({1'b0, w[7:0]});
    q.push_back({1'b0, w[15:8]});
  endfunction

  // Mostly well-formed records with random content; some cut short or padded
  function automatic void add_record(bit large_sel, bit alpha_on);
    int unsigned total;
    int unsigned bpp;
    int unsigned pos;
    int unsigned used;
    int unsigned trans;
    int unsigned cols;
    int unsigned n_pix;
    int unsigned size;
    int unsigned pick;
    rec_byte_t   body[$];
    rec_byte_t   rec[$];
    total = large_sel ? MAX_SIDE * MAX_SIDE : SMALL_SIDE * SMALL_SIDE;
    bpp   = alpha_on ? 4 : 3;
    pos   = 0;
    used  = 0;
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(99);
      if (pick < 8) trans = 16'hFFFF;
      else if (pick < 20 && pos + 4 < total) trans = total - pos - $urandom_range(1, 3);
      else trans = $urandom_range(0, 40);
      pick = $urandom_range(99);
      if (pick < 10) cols = $urandom_range(0, 16'hFFFF);
      else if (pick < 25) cols = 0;
      else cols = $urandom_range(1, 4);
      push_word(body, trans);
      push_word(body, cols);
      pos   = (pos + trans > total) ? total : pos + trans;
      used += RUN_HDR_BYTES + bpp * cols;
      n_pix = (cols < 5) ? cols : 5;
      if (n_pix > total - pos) n_pix = total - pos;
      repeat (n_pix * bpp) body.push_back({1'b0, 8'($urandom)});
      pos += n_pix;
      if (pos >= total) break;
    end
    if (used > 16'hFFFF) used = 16'hFFFF;
    pick = $urandom_range(99);
    if (pick < 70) size = used;
    else if (pick < 78) size = 0;
    else if (pick < 90) size = $urandom_range(1, used);
    else size = $urandom_range(0, 16'hFFFF);

    if (!large_sel) repeat (3) rec.push_back({1'b0, 8'($urandom)});
    push_word(rec, size);
    rec = {rec, body};
    rec[0].start = 1'b1;
    // broken record: cut anywhere after the first byte
    if ($urandom_range(99) < 10) rec = rec[0:$urandom_range(0, rec.size() - 2)];
    // trailing bytes with no record start
    if ($urandom_range(99) < 8)
      repeat ($urandom_range(1, 3)) rec.push_back({1'b0, 8'($urandom)});
    stim = {stim, rec};
  endfunction

  initial begin
    bit          l_sel;
    bit          a_sel;
    int unsigned sent_bytes;
    int unsigned phase_no;

    chk                = new();
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.record_start = 1'b0;
    px_ch.ready        = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_LARGE_SPRITES;
    cfg_ch.value       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: small sprite, RGBA pixels
    configure(1'b0, 1'b1);
    // byte outside any record
    stim.push_back({1'b0, 8'h5A});
    // record abandoned by a restart, then a zero payload size
    stim.push_back({1'b1, 8'hFF}); stim.push_back({1'b0, 8'h00});
    stim.push_back({1'b1, 8'h80}); stim.push_back({1'b0, 8'h00});
    stim.push_back({1'b0, 8'h00}); stim.push_back({1'b0, 8'h00});
    stim.push_back({1'b0, 8'h00});
    // skip to the last pixel, huge run saturates the payload count,
    // the one pixel read hits the image end and closes the record
    stim.push_back({1'b1, 8'hAA}); stim.push_back({1'b0, 8'hBB});
    stim.push_back({1'b0, 8'hCC});
    stim.push_back({1'b0, 8'hFF}); stim.push_back({1'b0, 8'hFF});
    stim.push_back({1'b0, 8'hFF}); stim.push_back({1'b0, 8'h03});
    stim.push_back({1'b0, 8'hFF}); stim.push_back({1'b0, 8'hFF});
    stim.push_back({1'b0, 8'h12}); stim.push_back({1'b0, 8'h34});
    stim.push_back({1'b0, 8'h56}); stim.push_back({1'b0, 8'h78});
    // byte after the record finished
    stim.push_back({1'b0, 8'hFF});
    // transparent skip saturates, run header lands on the image end
    stim.push_back({1'b1, 8'h01}); stim.push_back({1'b0, 8'h02});
    stim.push_back({1'b0, 8'h03});
    stim.push_back({1'b0, 8'h10}); stim.push_back({1'b0, 8'h00});
    stim.push_back({1'b0, 8'hFF}); stim.push_back({1'b0, 8'hFF});
    stim.push_back({1'b0, 8'h01}); stim.push_back({1'b0, 8'h00});
    send_stream();

    // Random records, several register settings, one phase without gaps
    sent_bytes = 0;
    phase_no   = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      case (phase_no)
        0: begin l_sel = 1'b0; a_sel = 1'b0; end
        1: begin l_sel = 1'b1; a_sel = 1'b1; end
        2: begin l_sel = 1'b0; a_sel = 1'b1; end
        3: begin l_sel = 1'b1; a_sel = 1'b0; end
        default: begin
          l_sel = $urandom_range(1);
          a_sel = $urandom_range(1);
        end
      endcase
      configure(l_sel, a_sel);
      gap_free = (phase_no == 2);
      while (stim.size() < PHASE_BYTES) add_record(l_sel, a_sel);
      sent_bytes += stim.size();
      send_stream();
      gap_free = 1'b0;
      phase_no++;
    end

    settle_idle();
    if (chk.errors == 0 && chk.expected_pixels.size() == 0) begin
      $display("PASS sprite_run_length_decoder");
    end else begin
      $display("FAIL sprite_run_length_decoder");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sprd_pkg.sv
src/sprd_if.sv
src/sprd_core.sv
src/sprd_skid.sv
src/sprite_run_length_decoder.sv
tb/tb_top.sv
